/* src/tpdt_pkg.sv */
package tpdt_pkg;

  localparam int unsigned TolWidth    = 32;
  localparam int unsigned StatusWidth = 2;
  localparam logic [TolWidth-1:0] TolReset = 32'd43;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [StatusWidth-1:0] {
    ST_MATCHED   = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the request, clear the match state
    logic scan_en;  // read the next table entry
    logic finish;   // resolve the request and present the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic addr_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

/* src/tpdt_if.sv */
interface tpdt_req_if #(
  parameter int unsigned COORD_WIDTH = 48
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [COORD_WIDTH-1:0] coord_r;
  logic signed [COORD_WIDTH-1:0] coord_z;

  modport source (output valid, op, coord_r, coord_z, input ready);
  modport sink   (input valid, op, coord_r, coord_z, output ready);
endinterface

interface tpdt_rsp_if #(
  parameter int unsigned TABLE_DEPTH = 1024
);
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  logic                               valid;
  logic                               ready;
  logic [IdxW-1:0]                    point_index;
  logic [tpdt_pkg::StatusWidth-1:0]   status;
  logic [CntW-1:0]                    unique_count;

  modport source (output valid, point_index, status, unique_count, input ready);
  modport sink   (input valid, point_index, status, unique_count, output ready);
endinterface

interface tpdt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tpdt_pkg::TolWidth-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/tpdt_ram.sv */
module tpdt_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/tpdt_ctrl.sv */
module tpdt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  tpdt_pkg::sts_t sts_i,
  output tpdt_pkg::cmd_t cmd_o
);
  import tpdt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.cnt_zero ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.addr_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the compare pipe to drain and the output slot to free up
        if (!sts_i.pipe_busy && sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/tpdt_dpath.sv */
module tpdt_dpath #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COORD_WIDTH = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tpdt_pkg::cmd_t                       cmd_i,
  output tpdt_pkg::sts_t                       sts_o,
  input  logic                                 op_i,
  input  logic signed [COORD_WIDTH-1:0]        coord_r_i,
  input  logic signed [COORD_WIDTH-1:0]        coord_z_i,
  input  logic                                 cfg_valid_i,
  input  logic [tpdt_pkg::TolWidth-1:0]        cfg_data_i,
  input  logic                                 rsp_ready_i,
  output logic                                 rsp_valid_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]       point_index_o,
  output logic [tpdt_pkg::StatusWidth-1:0]     status_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     unique_count_o
);
  import tpdt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DifW = COORD_WIDTH + 1;
  localparam int unsigned CmpW = (DifW > TolWidth) ? DifW : TolWidth;

  logic [TolWidth-1:0]    tol_q;
  logic                   op_q;
  logic [COORD_WIDTH-1:0] r_q, z_q;
  logic [CntW-1:0]        count_q, count_d;
  logic [IdxW-1:0]        addr_q;

  logic                   v1_q, v2_q;
  logic [IdxW-1:0]        idx1_q, idx2_q;
  logic [DifW-1:0]        absr_q, absz_q;
  logic                   hit_q;
  logic [IdxW-1:0]        hit_idx_q;

  logic [2*COORD_WIDTH-1:0] rd_data;
  logic [COORD_WIDTH-1:0]   ent_r, ent_z;
  logic signed [DifW-1:0]   dr_ab, dr_ba, dz_ab, dz_ba;
  logic [DifW-1:0]          absr_d, absz_d;
  logic                     match;

  logic                   full;
  logic                   we;
  logic [IdxW-1:0]        res_idx;
  status_e                res_status;

  logic                   out_valid_q;
  logic [IdxW-1:0]        out_idx_q;
  status_e                out_status_q;
  logic [CntW-1:0]        out_count_q;

  tpdt_ram #(
    .WIDTH (2 * COORD_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({r_q, z_q}),
    .re_i    (cmd_i.scan_en),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  assign ent_r = rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
  assign ent_z = rd_data[COORD_WIDTH-1:0];

  // sign-extend by one bit so the difference never wraps
  assign dr_ab  = $signed({r_q[COORD_WIDTH-1], r_q}) - $signed({ent_r[COORD_WIDTH-1], ent_r});
  assign dr_ba  = $signed({ent_r[COORD_WIDTH-1], ent_r}) - $signed({r_q[COORD_WIDTH-1], r_q});
  assign dz_ab  = $signed({z_q[COORD_WIDTH-1], z_q}) - $signed({ent_z[COORD_WIDTH-1], ent_z});
  assign dz_ba  = $signed({ent_z[COORD_WIDTH-1], ent_z}) - $signed({z_q[COORD_WIDTH-1], z_q});
  assign absr_d = dr_ab[DifW-1] ? dr_ba : dr_ab;
  assign absz_d = dz_ab[DifW-1] ? dz_ba : dz_ab;

  assign match = (CmpW'(absr_q) < CmpW'(tol_q)) && (CmpW'(absz_q) < CmpW'(tol_q));

  assign full = (count_q == CntW'(TABLE_DEPTH));

  always_comb begin
    we         = 1'b0;
    res_idx    = '0;
    res_status = ST_MATCHED;
    priority if (hit_q) begin
      res_idx    = hit_idx_q;
      res_status = ST_MATCHED;
    end else if (op_q == OP_LOOKUP) begin
      res_status = ST_NOT_FOUND;
    end else if (full) begin
      res_status = ST_FULL;
    end else begin
      res_idx    = count_q[IdxW-1:0];
      res_status = ST_INSERTED;
      we         = cmd_i.finish;
    end
  end

  assign count_d = we ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TolReset;
      count_q     <= '0;
      addr_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
      count_q <= count_d;
      if (cmd_i.load) begin
        addr_q <= '0;
      end else if (cmd_i.scan_en) begin
        addr_q <= addr_q + IdxW'(1);
      end
      v1_q <= cmd_i.scan_en;
      v2_q <= v1_q;
      // later entries override earlier ones: last match wins
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (v2_q && match) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      r_q  <= coord_r_i;
      z_q  <= coord_z_i;
    end
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
    absr_q <= absr_d;
    absz_q <= absz_d;
    if (v2_q && match) begin
      hit_idx_q <= idx2_q;
    end
    if (cmd_i.finish) begin
      out_idx_q    <= res_idx;
      out_status_q <= res_status;
      out_count_q  <= count_d;
    end
  end

  assign sts_o.cnt_zero  = (count_q == '0);
  assign sts_o.addr_last = ((CntW'(addr_q) + CntW'(1)) == count_q);
  assign sts_o.pipe_busy = v1_q || v2_q;
  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o    = out_valid_q;
  assign point_index_o  = out_idx_q;
  assign status_o       = out_status_q;
  assign unique_count_o = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_en |-> (CntW'(addr_q) < count_q))
    else $error("scan reads an entry beyond the fill count");

  a_no_write_while_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !(cmd_i.scan_en || v1_q || v2_q))
    else $error("table write while compare pipe is busy");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && res_status == ST_INSERTED) |=>
      (count_q == $past(count_q) + CntW'(1)) && (out_count_q == count_q))
    else $error("insert did not advance the entry count");

endmodule

/* src/tolerant_point_dedup_table.sv */
// Scan: the N stored entries (N = entry count) are compared after a request is accepted;
//   one entry per cycle is read from the single table RAM; with N = 0 the scan is skipped.
// Requests: one request at a time; the next
//   is taken the cycle after the result is handed to the output register, which holds
//   it until the sink takes it. Reset: rst_ni clears the entry count, control state
//   and output valid, loads the tolerance with 43; table contents are not cleared.
module tolerant_point_dedup_table #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COORD_WIDTH = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpdt_req_if.sink   req,
  tpdt_rsp_if.source rsp,
  tpdt_cfg_if.sink   cfg
);
  import tpdt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  tpdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tpdt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (req.op),
    .coord_r_i      (req.coord_r),
    .coord_z_i      (req.coord_z),
    .cfg_valid_i    (cfg.valid),
    .cfg_data_i     (cfg.data),
    .rsp_ready_i    (rsp.ready),
    .rsp_valid_o    (rsp.valid),
    .point_index_o  (rsp.point_index),
    .status_o       (rsp.status),
    .unique_count_o (rsp.unique_count)
  );

endmodule
